// ===== design/astar_pkg.sv =====
package astar_pkg;

   localparam int NODES    = 32;
   localparam int EDGES    = 128;
   localparam int NODE_W   = 5;
   localparam int EIDX_W   = $clog2(EDGES);
   localparam int ECNT_W   = $clog2(EDGES + 1);
   localparam int EST_W    = 16;
   localparam int COST_W   = 22;
   localparam int F_W      = COST_W + 1;
   localparam int PATH_CAP = (NODES < 32 ? NODES : 32) - 1;
   localparam int PCNT_W   = $clog2(PATH_CAP + 1);
   localparam int CSR_IDX_W = 1;

   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_EST    = 2'd1;
   localparam logic [1:0] REQ_EDGE   = 2'd2;
   localparam logic [1:0] REQ_SEARCH = 2'd3;

   localparam logic [1:0] MARK_NONE   = 2'd0;
   localparam logic [1:0] MARK_OPEN   = 2'd1;
   localparam logic [1:0] MARK_CLOSED = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_START = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL  = 1'b1;

   typedef struct packed {
      logic init;
      logic scan;
      logic close;
      logic edge_chk;
      logic edge_upd;
      logic walk_init;
      logic walk_step;
      logic out_start;
      logic out_buf;
      logic out_nf;
   } cmd_type;

   typedef struct packed {
      logic bad_node;
      logic scan_end;
      logic best_vld;
      logic best_is_goal;
      logic no_edges;
      logic edge_end;
      logic walk_more;
      logic path_empty;
      logic emit_end;
      logic out_free;
   } sts_type;

endpackage

// ===== design/a_star_shortest_path_core.sv =====
// channel   | direction | handshake         | payload
// ----------+-----------+-------------------+------------------------------------------
// req_      | in        | req_valid/stall   | req_type, req_from_node, req_to_node, req_value
// rsp_      | out       | rsp_valid/stall   | found, path_node, total_cost, last
// csr_      | in        | csr_wr_en         | csr_index, csr_wdata (start, goal)
//
// clear, estimate and edge requests are taken while idle and leave the sequencer idle
// a search repeats the one-node-per-cycle open scan and, per expansion, the edge relax
//   through the cost memory in states EA, EB and EC, then walks the parent pointers
// and emits the start node and then each later node; not found emits a single item
// reset is synchronous and clears control state, estimate valid bits and the edge count
// rsp_stall holds the output register; the emit sequencer waits on it
module a_star_shortest_path_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_type,
   input  logic [astar_pkg::NODE_W-1:0]       req_from_node,
   input  logic [astar_pkg::NODE_W-1:0]       req_to_node,
   input  logic [astar_pkg::EST_W-1:0]        req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_found,
   output logic [astar_pkg::NODE_W-1:0]       rsp_path_node,
   output logic [astar_pkg::COST_W-1:0]       rsp_total_cost,
   output logic                               rsp_last,
   input  logic                               csr_wr_en,
   input  logic [astar_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [astar_pkg::NODE_W-1:0]       csr_wdata
);
   import astar_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    req_accept;

   // a request is taken only while the sequencer is idle
   assign req_accept = req_valid && !req_stall;

   astar_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_type   (req_type),
      .sts        (sts),
      .cmd        (cmd),
      .req_stall  (req_stall)
   );

   // node state, edge list, open scan, parent walk and output register
   astar_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_accept     (req_accept),
      .req_type       (req_type),
      .req_from_node  (req_from_node),
      .req_to_node    (req_to_node),
      .req_value      (req_value),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_found      (rsp_found),
      .rsp_path_node  (rsp_path_node),
      .rsp_total_cost (rsp_total_cost),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== design/astar_ctrl.sv =====
module astar_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_accept,
   input  logic [1:0]        req_type,
   input  astar_pkg::sts_type sts,
   output astar_pkg::cmd_type cmd,
   output logic              req_stall
);
   import astar_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_NF     = 4'd1;
   localparam logic [3:0] ST_INIT   = 4'd2;
   localparam logic [3:0] ST_SCAN   = 4'd3;
   localparam logic [3:0] ST_SWAIT  = 4'd4;
   localparam logic [3:0] ST_DECIDE = 4'd5;
   localparam logic [3:0] ST_EA     = 4'd6;
   localparam logic [3:0] ST_EB     = 4'd7;
   localparam logic [3:0] ST_EC     = 4'd8;
   localparam logic [3:0] ST_WINIT  = 4'd9;
   localparam logic [3:0] ST_WA     = 4'd10;
   localparam logic [3:0] ST_WB     = 4'd11;
   localparam logic [3:0] ST_ES     = 4'd12;
   localparam logic [3:0] ST_BR     = 4'd13;
   localparam logic [3:0] ST_BL     = 4'd14;

   logic [3:0] state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_type == REQ_SEARCH) begin
               state_in = sts.bad_node ? ST_NF : ST_INIT;
            end
         end
         ST_NF: begin
            if (sts.out_free) begin
               cmd.out_nf = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_end) state_in = ST_SWAIT;
         end
         ST_SWAIT: state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (!sts.best_vld) begin
               state_in = ST_NF;
            end else begin
               cmd.close = 1'b1;
               if (sts.best_is_goal) state_in = ST_WINIT;
               else if (sts.no_edges) state_in = ST_SCAN;
               else state_in = ST_EA;
            end
         end
         ST_EA: state_in = ST_EB;
         ST_EB: begin
            cmd.edge_chk = 1'b1;
            state_in     = ST_EC;
         end
         ST_EC: begin
            cmd.edge_upd = 1'b1;
            state_in     = sts.edge_end ? ST_SCAN : ST_EA;
         end
         ST_WINIT: begin
            cmd.walk_init = 1'b1;
            state_in      = ST_WA;
         end
         ST_WA: state_in = ST_WB;
         ST_WB: begin
            if (sts.walk_more) begin
               cmd.walk_step = 1'b1;
               state_in      = ST_WA;
            end else begin
               state_in = ST_ES;
            end
         end
         ST_ES: begin
            if (sts.out_free) begin
               cmd.out_start = 1'b1;
               state_in      = sts.path_empty ? ST_IDLE : ST_BR;
            end
         end
         ST_BR: state_in = ST_BL;
         ST_BL: begin
            if (sts.out_free) begin
               cmd.out_buf = 1'b1;
               state_in    = sts.emit_end ? ST_IDLE : ST_BR;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

// ===== design/astar_dp.sv =====
module astar_dp (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_accept,
   input  logic [1:0]                               req_type,
   input  logic [astar_pkg::NODE_W-1:0]             req_from_node,
   input  logic [astar_pkg::NODE_W-1:0]             req_to_node,
   input  logic [astar_pkg::EST_W-1:0]              req_value,
   input  logic                                     csr_wr_en,
   input  logic [astar_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [astar_pkg::NODE_W-1:0]             csr_wdata,
   input  astar_pkg::cmd_type                       cmd,
   output astar_pkg::sts_type                       sts,
   input  logic                                     rsp_stall,
   output logic                                     rsp_valid,
   output logic                                     rsp_found,
   output logic [astar_pkg::NODE_W-1:0]             rsp_path_node,
   output logic [astar_pkg::COST_W-1:0]             rsp_total_cost,
   output logic                                     rsp_last
);
   import astar_pkg::*;

   logic [NODE_W-1:0] start_ff, goal_ff;

   // estimate store with per-entry valid bits (invalid reads as zero)
   logic [EST_W-1:0]  est_mem [NODES];
   logic [NODES-1:0]  est_vld_ff;
   logic [EST_W-1:0]  est_rd_ff;
   logic              est_ok_ff;

   logic [COST_W-1:0] g_mem [NODES];
   logic [COST_W-1:0] g_rd_ff;
   logic [NODE_W-1:0] par_mem [NODES];
   logic [EST_W-1:0]  pc_mem [NODES];
   logic [NODE_W-1:0] par_rd_ff;
   logic [EST_W-1:0]  pc_rd_ff;

   logic [NODE_W-1:0] esrc_mem [EDGES];
   logic [NODE_W-1:0] etgt_mem [EDGES];
   logic [EST_W-1:0]  ewt_mem [EDGES];
   logic [NODE_W-1:0] esrc_rd_ff, etgt_rd_ff;
   logic [EST_W-1:0]  ewt_rd_ff;
   logic [ECNT_W-1:0] ecnt_ff;
   logic [EIDX_W-1:0] eidx_ff;
   logic              ematch_ff;

   logic [1:0]        mark_ff [NODES];
   logic [NODES-1:0]  hp_ff;

   logic [NODE_W-1:0] scan_idx_ff, si_ff;
   logic              sv_ff;
   logic              best_vld_ff;
   logic [NODE_W-1:0] best_idx_ff;
   logic [F_W-1:0]    best_f_ff;
   logic [COST_W-1:0] best_g_ff;

   logic [NODE_W-1:0] ws_ff;
   logic [PCNT_W-1:0] wn_ff, emit_idx_ff;
   logic [COST_W-1:0] wcost_ff;
   logic [NODE_W-1:0] buf_mem [PATH_CAP];
   logic [NODE_W-1:0] buf_rd_ff;

   logic              rsp_valid_ff, rsp_found_ff, rsp_last_ff;
   logic [NODE_W-1:0] rsp_node_ff;
   logic [COST_W-1:0] rsp_cost_ff;

   logic              est_we, edge_we, clr_nodes;
   logic [F_W-1:0]    scan_f;
   logic              scan_take;
   logic [COST_W-1:0] ng;
   logic              upd_go;
   logic              g_we;
   logic [NODE_W-1:0] g_waddr, g_raddr;
   logic              out_load;

   assign est_we  = req_accept && req_type == REQ_EST
                    && ({1'b0, req_from_node} < (NODE_W+1)'(NODES));
   assign edge_we = req_accept && req_type == REQ_EDGE
                    && ({1'b0, req_from_node} < (NODE_W+1)'(NODES))
                    && ({1'b0, req_to_node} < (NODE_W+1)'(NODES))
                    && (ecnt_ff < ECNT_W'(EDGES));
   assign clr_nodes = (req_accept && req_type == REQ_CLEAR) || cmd.init;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         goal_ff  <= '0;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_START) start_ff <= csr_wdata;
         if (csr_index == CSR_GOAL) goal_ff <= csr_wdata;
      end
   end

   // estimate store
   always_ff @(posedge clock) begin
      if (est_we) est_mem[req_from_node] <= req_value;
      est_rd_ff <= est_mem[scan_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset || (req_accept && req_type == REQ_CLEAR)) begin
         est_vld_ff <= '0;
      end else if (est_we) begin
         est_vld_ff[req_from_node] <= 1'b1;
      end
      est_ok_ff <= est_vld_ff[scan_idx_ff];
   end

   // edge list
   always_ff @(posedge clock) begin
      if (edge_we) begin
         esrc_mem[ecnt_ff[EIDX_W-1:0]] <= req_from_node;
         etgt_mem[ecnt_ff[EIDX_W-1:0]] <= req_to_node;
         ewt_mem[ecnt_ff[EIDX_W-1:0]]  <= req_value;
      end
      esrc_rd_ff <= esrc_mem[eidx_ff];
      etgt_rd_ff <= etgt_mem[eidx_ff];
      ewt_rd_ff  <= ewt_mem[eidx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset || (req_accept && req_type == REQ_CLEAR)) ecnt_ff <= '0;
      else if (edge_we) ecnt_ff <= ecnt_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eidx_ff <= '0;
      end else if (cmd.close) begin
         eidx_ff <= '0;
      end else if (cmd.edge_upd) begin
         eidx_ff <= sts.edge_end ? '0 : eidx_ff + 1'b1;
      end
      if (cmd.edge_chk) ematch_ff <= (esrc_rd_ff == best_idx_ff);
   end

   // relaxation of one edge
   assign ng     = best_g_ff + COST_W'(ewt_rd_ff);
   assign upd_go = cmd.edge_upd && ematch_ff
                   && (mark_ff[etgt_rd_ff] == MARK_NONE || ng < g_rd_ff);
   assign g_we    = cmd.init || upd_go;
   assign g_waddr = cmd.init ? start_ff : etgt_rd_ff;
   assign g_raddr = cmd.edge_chk ? etgt_rd_ff : scan_idx_ff;

   always_ff @(posedge clock) begin
      if (g_we) g_mem[g_waddr] <= cmd.init ? '0 : ng;
      g_rd_ff <= g_mem[g_raddr];
   end

   always_ff @(posedge clock) begin
      if (upd_go) begin
         par_mem[etgt_rd_ff] <= best_idx_ff;
         pc_mem[etgt_rd_ff]  <= ewt_rd_ff;
      end
      par_rd_ff <= par_mem[ws_ff];
      pc_rd_ff  <= pc_mem[ws_ff];
   end

   always_ff @(posedge clock) begin
      if (reset || clr_nodes) begin
         // a search start opens its start node while the rest are cleared
         for (int i = 0; i < NODES; i++)
            mark_ff[i] <= (cmd.init && NODE_W'(i) == start_ff) ? MARK_OPEN : MARK_NONE;
         hp_ff <= '0;
      end else begin
         if (cmd.close) mark_ff[best_idx_ff] <= MARK_CLOSED;
         if (upd_go) begin
            mark_ff[etgt_rd_ff] <= MARK_OPEN;
            hp_ff[etgt_rd_ff]   <= 1'b1;
         end
      end
   end

   // open-list scan, one node per cycle
   assign scan_f    = {1'b0, g_rd_ff} + F_W'(est_ok_ff ? est_rd_ff : '0);
   assign scan_take = sv_ff && mark_ff[si_ff] == MARK_OPEN
                      && (!best_vld_ff || scan_f < best_f_ff
                          || (scan_f == best_f_ff && g_rd_ff > best_g_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         sv_ff       <= 1'b0;
         best_vld_ff <= 1'b0;
      end else begin
         sv_ff <= cmd.scan;
         if (cmd.init) begin
            scan_idx_ff <= '0;
         end else if (cmd.scan) begin
            scan_idx_ff <= sts.scan_end ? '0 : scan_idx_ff + 1'b1;
         end
         if (cmd.scan && scan_idx_ff == '0) best_vld_ff <= 1'b0;
         else if (scan_take) best_vld_ff <= 1'b1;
      end
      si_ff <= scan_idx_ff;
      if (scan_take) begin
         best_idx_ff <= si_ff;
         best_f_ff   <= scan_f;
         best_g_ff   <= g_rd_ff;
      end
   end

   // parent walk and path buffer
   always_ff @(posedge clock) begin
      if (cmd.walk_init) begin
         ws_ff    <= goal_ff;
         wn_ff    <= '0;
         wcost_ff <= '0;
      end else if (cmd.walk_step) begin
         buf_mem[wn_ff] <= ws_ff;
         wcost_ff <= wcost_ff + COST_W'(pc_rd_ff);
         ws_ff    <= par_rd_ff;
         wn_ff    <= wn_ff + 1'b1;
      end
      buf_rd_ff <= buf_mem[emit_idx_ff];
      if (cmd.out_start) emit_idx_ff <= wn_ff - 1'b1;
      else if (cmd.out_buf) emit_idx_ff <= emit_idx_ff - 1'b1;
   end

   // output register
   assign out_load = cmd.out_start || cmd.out_buf || cmd.out_nf;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_found_ff <= !cmd.out_nf;
         rsp_node_ff  <= cmd.out_nf ? '0 : (cmd.out_start ? start_ff : buf_rd_ff);
         rsp_cost_ff  <= cmd.out_nf ? '0 : wcost_ff;
         rsp_last_ff  <= cmd.out_nf || (cmd.out_start && wn_ff == '0)
                         || (cmd.out_buf && emit_idx_ff == '0);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_path_node  = rsp_node_ff;
   assign rsp_total_cost = rsp_cost_ff;
   assign rsp_last       = rsp_last_ff;

   always_comb begin
      sts.bad_node     = ({1'b0, start_ff} >= (NODE_W+1)'(NODES))
                         || ({1'b0, goal_ff} >= (NODE_W+1)'(NODES));
      sts.scan_end     = (scan_idx_ff == NODE_W'(NODES - 1));
      sts.best_vld     = best_vld_ff;
      sts.best_is_goal = (best_idx_ff == goal_ff);
      sts.no_edges     = (ecnt_ff == '0);
      sts.edge_end     = ({1'b0, eidx_ff} + 1'b1 == ecnt_ff);
      sts.walk_more    = (wn_ff < PCNT_W'(PATH_CAP)) && hp_ff[ws_ff];
      sts.path_empty   = (wn_ff == '0);
      sts.emit_end     = (emit_idx_ff == '0);
      sts.out_free     = !rsp_valid_ff || !rsp_stall;
   end

endmodule

// ===== design/astar_checker.sv =====
module astar_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic [1:0]                         req_type,
   input logic [astar_pkg::NODE_W-1:0]       req_from_node,
   input logic [astar_pkg::NODE_W-1:0]       req_to_node,
   input logic [astar_pkg::EST_W-1:0]        req_value,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic                               rsp_found,
   input logic [astar_pkg::NODE_W-1:0]       rsp_path_node,
   input logic [astar_pkg::COST_W-1:0]       rsp_total_cost,
   input logic                               rsp_last,
   input logic                               csr_wr_en,
   input logic [astar_pkg::CSR_IDX_W-1:0]    csr_index,
   input logic [astar_pkg::NODE_W-1:0]       csr_wdata
);
   import astar_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_nf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last && rsp_path_node == '0 && rsp_total_cost == '0)
      else $error("not-found result malformed");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_type == REQ_SEARCH |=> req_stall)
      else $error("search request did not block input");

   a_cost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last ##1 rsp_valid
      |-> rsp_found && rsp_total_cost == $past(rsp_total_cost))
      else $error("path cost changed within one search");

endmodule

bind a_star_shortest_path_core astar_checker u_astar_checker (.*);

// ===== dv/a_star_shortest_path_core_tb.sv =====
module a_star_shortest_path_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import astar_pkg::*;

   localparam int STALL_LIMIT = 500000;   // cycles with nothing accepted
   localparam int DRAIN_CYCLES = 200;

   // ------------------------------------------------------------------
   // path scoreboard: its own copy of the graph, the registers and a
   // software a* search; queues the expected path items per request
   // ------------------------------------------------------------------
   class path_scoreboard;
      typedef struct {
         bit        found;
         bit [4:0]  node;
         bit [21:0] cost;
         bit        last;
      } path_item_type;

      bit [15:0]      est[NODES];
      bit [4:0]       edge_from[EDGES];
      bit [4:0]       edge_to[EDGES];
      bit [15:0]      edge_cost[EDGES];
      int             edge_total;
      bit [4:0]       start_reg;
      bit [4:0]       goal_reg;
      path_item_type  pending[$];
      int             errors;

      function void set_reg(logic idx, bit [4:0] data);
         if (idx == CSR_START)
            start_reg = data;
         else
            goal_reg = data;
      endfunction

      function void push_item(bit f, bit [4:0] n, bit [21:0] c, bit l);
         path_item_type it;
         it.found = f;
         it.node  = n;
         it.cost  = c;
         it.last  = l;
         pending = {pending, it};
      endfunction

      function void note_request(logic [1:0] kind, bit [4:0] a, bit [4:0] b, bit [15:0] v);
         logic [1:0]  mark[NODES];
         int unsigned g[NODES];
         bit [4:0]    parent[NODES];
         bit [15:0]   pcost[NODES];
         bit          has_parent[NODES];
         bit [4:0]    trail[$];
         int          best;
         int unsigned bf, bg, f, ng;
         bit          reached;
         int unsigned sum;
         bit [4:0]    s;
         case (kind)
            REQ_CLEAR: begin
               foreach (est[i]) est[i] = '0;
               edge_total = 0;
            end
            REQ_EST: est[a] = v;
            REQ_EDGE: begin
               if (edge_total < EDGES) begin
                  edge_from[edge_total] = a;
                  edge_to[edge_total]   = b;
                  edge_cost[edge_total] = v;
                  edge_total++;
               end
            end
            default: begin
               foreach (mark[i]) begin
                  mark[i] = MARK_NONE;
                  g[i] = 0;
                  has_parent[i] = 0;
               end
               mark[start_reg] = MARK_OPEN;
               reached = 0;
               forever begin
                  best = -1;
                  bf = 0;
                  bg = 0;
                  for (int i = 0; i < NODES; i++) begin
                     if (mark[i] != MARK_OPEN) continue;
                     f = g[i] + est[i];
                     if (best < 0 || f < bf || (f == bf && g[i] > bg)) begin
                        best = i;
                        bf = f;
                        bg = g[i];
                     end
                  end
                  if (best < 0) break;
                  mark[best] = MARK_CLOSED;
                  if (best == goal_reg) begin
                     reached = 1;
                     break;
                  end
                  for (int e = 0; e < edge_total; e++) begin
                     if (edge_from[e] != best) continue;
                     ng = g[best] + edge_cost[e];
                     if (mark[edge_to[e]] != MARK_NONE && ng >= g[edge_to[e]]) continue;
                     g[edge_to[e]]          = ng;
                     parent[edge_to[e]]     = best[4:0];
                     pcost[edge_to[e]]      = edge_cost[e];
                     has_parent[edge_to[e]] = 1;
                     mark[edge_to[e]]       = MARK_OPEN;
                  end
               end
               if (!reached) begin
                  push_item(0, '0, '0, 1);
               end else begin
                  // walk back from the goal, capped
                  sum = 0;
                  s = goal_reg;
                  while (trail.size() < PATH_CAP && has_parent[s]) begin
                     trail.push_front(s);
                     sum += pcost[s];
                     s = parent[s];
                  end
                  push_item(1, start_reg, sum[21:0], trail.size() == 0);
                  foreach (trail[i])
                     push_item(1, trail[i], sum[21:0], i == trail.size() - 1);
               end
            end
         endcase
      endfunction

      function void check_result(bit f, bit [4:0] n, bit [21:0] c, bit l);
         path_item_type x;
         if (pending.size() == 0) begin
            $display("%0t: unexpected path item found=%0d node=%0d cost=%0d last=%0d",
                     $time, f, n, c, l);
            errors++;
            return;
         end
         x = pending.pop_front();
         if (x.found != f) begin
            $display("%0t: found expected %0d actual %0d", $time, x.found, f);
            errors++;
         end
         if (x.node != n) begin
            $display("%0t: path_node expected %0d actual %0d", $time, x.node, n);
            errors++;
         end
         if (x.cost != c) begin
            $display("%0t: total_cost expected %0d actual %0d", $time, x.cost, c);
            errors++;
         end
         if (x.last != l) begin
            $display("%0t: last expected %0d actual %0d", $time, x.last, l);
            errors++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [1:0]           req_type;
   logic [NODE_W-1:0]    req_from_node;
   logic [NODE_W-1:0]    req_to_node;
   logic [EST_W-1:0]     req_value;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_found;
   logic [NODE_W-1:0]    rsp_path_node;
   logic [COST_W-1:0]    rsp_total_cost;
   logic                 rsp_last;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [NODE_W-1:0]    csr_wdata;

   path_scoreboard sb = new();
   int send_idle_pct;     // chance of an idle cycle before a request
   int rsp_stall_pct;     // chance of stalling the result channel
   int sent;
   int quiet_cycles;

   a_star_shortest_path_core i_dut (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // result side: check on every accepted path item, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_found, rsp_path_node, rsp_total_cost, rsp_last);
      rsp_stall <= !reset && ($urandom_range(99) < rsp_stall_pct);
   end

   // watchdog: nothing accepted on either side for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("a_star_shortest_path_core test failed");
         $finish;
      end
   end

   // one request; valid stays high on return so back-to-back requests
   // never drop it inside a step
   task automatic send_req(logic [1:0] kind, bit [4:0] a, bit [4:0] b, bit [15:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_from_node <= a;
      req_to_node   <= b;
      req_value     <= v;
      do @(posedge clock); while (req_stall);
      sb.note_request(kind, a, b, v);
      sent++;
   endtask

   // wait for the block to go idle, then write start and goal
   task automatic set_endpoints(bit [4:0] s, bit [4:0] g);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);   // last load may still be in flight
      csr_wr_en <= 1'b1;
      csr_index <= CSR_START;
      csr_wdata <= s;
      @(posedge clock);
      csr_index <= CSR_GOAL;
      csr_wdata <= g;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_reg(CSR_START, s);
      sb.set_reg(CSR_GOAL, g);
   endtask

   // edge cost: mostly small so that alternatives compete, sometimes huge
   function automatic bit [15:0] pick_cost();
      case ($urandom_range(9))
         0:       return 16'd0;
         1:       return 16'hffff;
         2, 3:    return 16'($urandom);
         default: return 16'($urandom_range(1, 20));
      endcase
   endfunction

   initial begin
      int n, m, graph;
      bit [4:0] order[$];
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_type      <= REQ_CLEAR;
      req_from_node <= '0;
      req_to_node   <= '0;
      req_value     <= '0;
      rsp_stall     <= 1'b0;
      csr_wr_en     <= 1'b0;
      csr_index     <= CSR_START;
      csr_wdata     <= '0;
      quiet_cycles  <= 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: start equals goal on an empty graph
      send_req(REQ_SEARCH, 5'd0, 5'd0, 16'd0);
      // not found on an empty graph
      set_endpoints(5'd0, 5'd31);
      send_req(REQ_SEARCH, 5'd0, 5'd0, 16'd0);
      // extreme estimate, self loop of zero cost, zero-cost and max-cost edges
      send_req(REQ_EST, 5'd31, 5'd0, 16'hffff);
      send_req(REQ_EST, 5'd0, 5'd0, 16'hffff);
      send_req(REQ_EDGE, 5'd31, 5'd0, 16'hffff);
      send_req(REQ_EDGE, 5'd0, 5'd31, 16'hffff);
      send_req(REQ_EDGE, 5'd0, 5'd0, 16'd0);
      send_req(REQ_EDGE, 5'd0, 5'd15, 16'd0);
      send_req(REQ_EDGE, 5'd15, 5'd0, 16'd0);      // zero-cost cycle
      send_req(REQ_EDGE, 5'd15, 5'd31, 16'h7fff);
      send_req(REQ_SEARCH, 5'd0, 5'd0, 16'd0);
      // reversed direction, goal unreachable except via the heavy edge
      set_endpoints(5'd31, 5'd15);
      send_req(REQ_SEARCH, 5'd0, 5'd0, 16'd0);
      // clear drops everything: not found again
      send_req(REQ_CLEAR, 5'd0, 5'd0, 16'd0);
      send_req(REQ_SEARCH, 5'd0, 5'd0, 16'd0);

      // random graphs, each in its own idling phase
      graph = 0;
      while (sent < 280) begin
         case (graph % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 63; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 63; end
            default: begin send_idle_pct = 30; rsp_stall_pct = 30; end
         endcase
         if (graph == 1) begin
            // long chain in shuffled load order: path hits the walk cap
            set_endpoints(5'd0, 5'd31);
            send_req(REQ_CLEAR, 5'd0, 5'd0, 16'd0);
            order.delete();
            for (int i = 0; i < 31; i++) order = {order, 5'(i)};
            order.shuffle();
            foreach (order[i])
               send_req(REQ_EDGE, order[i], order[i] + 5'd1, 16'($urandom_range(0, 65535)));
            send_req(REQ_SEARCH, 5'd0, 5'd0, 16'd0);
         end else if (graph == 2) begin
            // more edges than the store holds: the tail is dropped
            set_endpoints(5'($urandom_range(31)), 5'($urandom_range(31)));
            send_req(REQ_CLEAR, 5'd0, 5'd0, 16'd0);
            for (int i = 0; i < EDGES + 8; i++)
               send_req(REQ_EDGE, 5'($urandom_range(31)), 5'($urandom_range(31)),
                        pick_cost());
            send_req(REQ_SEARCH, 5'd0, 5'd0, 16'd0);
         end else begin
            n = $urandom_range(3, 32);
            m = $urandom_range(n, (3 * n > 60) ? 60 : 3 * n);
            set_endpoints(5'($urandom_range(n - 1)),
                          ($urandom_range(9) == 0) ? 5'($urandom_range(31))
                                                   : 5'($urandom_range(n - 1)));
            send_req(REQ_CLEAR, 5'd0, 5'd0, 16'd0);
            for (int i = 0; i < n / 2; i++)
               send_req(REQ_EST, 5'($urandom_range(n - 1)),
                        5'($urandom_range(31)),   // ignored field, random anyway
                        ($urandom_range(7) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, 30)));
            for (int i = 0; i < m; i++)
               send_req(REQ_EDGE, 5'($urandom_range(n - 1)), 5'($urandom_range(n - 1)),
                        pick_cost());
            send_req(REQ_SEARCH, 5'($urandom), 5'($urandom), 16'($urandom));
            // noise: a changed estimate or an extra edge, then search again
            for (int k = $urandom_range(2); k > 0; k--) begin
               if ($urandom_range(1))
                  send_req(REQ_EST, 5'($urandom), 5'($urandom), 16'($urandom));
               else
                  send_req(REQ_EDGE, 5'($urandom), 5'($urandom), pick_cost());
               send_req(REQ_SEARCH, 5'($urandom), 5'($urandom), 16'($urandom));
            end
         end
         graph++;
      end

      // drain
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("a_star_shortest_path_core test passed");
      else
         $display("a_star_shortest_path_core test failed");
      $finish;
   end

endmodule
